// ===== hw/rtl/kwm_pkg.sv =====
package kwm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int BESSEL_W = 48;
    localparam int WEIGHT_W = 31;

    localparam logic [BESSEL_W-1:0] ONE_Q28  = BESSEL_W'(64'd1 << 28);
    localparam logic [BESSEL_W-1:0] MAX_Q28  = {BESSEL_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] ONE_Q30  = WEIGHT_W'(64'd1 << 30);
    localparam logic [15:0]         OUT_GAIN = 16'd32767;

    typedef enum logic {
        CFG_FRAME_LENGTH = 1'b0,
        CFG_BETA         = 1'b1
    } cfg_index_t;

    // Shared datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  steps;
    } unit_req_t;

endpackage

// ===== hw/rtl/kaiser_window_multiplier_core.sv =====
// Kaiser window multiplier: scales each signed 16-bit sample by the Kaiser
// weight I0(beta*sqrt(1-r^2))/I0(beta) for its place in a frame of
// frame_length samples, flags the last sample of each frame and restarts the
// index. One sample is worked at a time on a single shared multiply/divide/
// square-root unit; each of the SERIES_TERMS series terms (50 by default)
// costs one multiply and one divide, and the first sample of a frame takes
// longer while I0(beta) is refreshed. The user must write configuration only
// while no sample is in flight; the core itself does not enforce this.
module kaiser_window_multiplier_core #(
    parameter int SERIES_TERMS = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_sample_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_sample_out,
    output logic        m_frame_last
);
    import kwm_pkg::*;

    logic [CFG_W-1:0] frame_length_reg;
    logic [CFG_W-1:0] beta_reg;
    logic             u_start;
    unit_req_t        u_req;
    logic             u_done;
    logic [127:0]     u_result;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= 16'd1024;
            beta_reg         <= 16'd20480;
        end else if (cfg_we) begin
            if (cfg_index == CFG_FRAME_LENGTH) frame_length_reg <= cfg_data;
            else                               beta_reg         <= cfg_data;
        end
    end

    kwm_unit u_unit (
        .aclk, .aresetn,
        .start(u_start), .req(u_req), .done(u_done), .result(u_result)
    );

    kwm_seq #(.SERIES_TERMS(SERIES_TERMS)) u_seq (
        .aclk, .aresetn,
        .frame_length(frame_length_reg), .beta(beta_reg),
        .in_valid(s_valid), .in_sample(s_sample_in), .in_ready(s_ready),
        .res_valid(m_valid), .res_ready(m_ready),
        .res_sample(m_sample_out), .res_last(m_frame_last),
        .u_start, .u_req, .u_done, .u_result
    );

endmodule

// ===== hw/rtl/kwm_unit.sv =====
// Shared multi-cycle arithmetic unit: shift-add multiply (64x64 -> 128, 2 bits
// a cycle), restoring divide (one quotient bit a cycle), integer square root
// (one result bit a cycle).
module kwm_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  kwm_pkg::unit_req_t  req,
    output logic                done,
    output logic [127:0]        result
);
    import kwm_pkg::*;

    op_t          op_reg;
    logic [127:0] acc_reg;
    logic [127:0] mcand_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  r_reg;
    logic [63:0]  bit_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [64:0]  rsh;
    logic [63:0]  trial;
    logic [127:0] mul_add;

    always_comb begin
        rsh     = {r_reg, a_reg[63]};
        trial   = r_reg + bit_reg;
        mul_add = acc_reg
                + (b_reg[0] ? mcand_reg : 128'd0)
                + (b_reg[1] ? {mcand_reg[126:0], 1'b0} : 128'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_NONE;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                op_reg    <= req.op;
                cnt_reg   <= req.steps;
                a_reg     <= req.a;
                b_reg     <= req.b;
                mcand_reg <= {64'd0, req.a};
                r_reg     <= 64'd0;
                acc_reg   <= 128'd0;
                bit_reg   <= 64'd1 << 62;
            end else if (busy_reg) begin
                unique case (op_reg)
                    OP_MUL: begin
                        // multiplicand shifts in the full product width
                        acc_reg   <= mul_add;
                        mcand_reg <= {mcand_reg[125:0], 2'b00};
                        b_reg     <= {2'b00, b_reg[63:2]};
                    end
                    OP_DIV: begin
                        // a: dividend shifting out, b: divisor
                        a_reg <= {a_reg[62:0], 1'b0};
                        if (rsh >= {1'b0, b_reg}) begin
                            r_reg   <= 64'(rsh - {1'b0, b_reg});
                            acc_reg <= {acc_reg[126:0], 1'b1};
                        end else begin
                            r_reg   <= rsh[63:0];
                            acc_reg <= {acc_reg[126:0], 1'b0};
                        end
                    end
                    OP_SQRT: begin
                        // a: remaining value, r: root
                        if (a_reg >= trial) begin
                            a_reg <= a_reg - trial;
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end else begin
                            r_reg <= r_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                        acc_reg <= 128'd0;
                    end
                    default: ;
                endcase
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_SQRT) ? {64'd0, r_reg} : acc_reg;

endmodule

// ===== hw/rtl/kwm_seq.sv =====
// Sequencer: walks one sample through the weight computation on the unit.
module kwm_seq #(
    parameter int SERIES_TERMS = 50
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [kwm_pkg::CFG_W-1:0]       frame_length,
    input  logic [kwm_pkg::CFG_W-1:0]       beta,
    input  logic                            in_valid,
    input  logic signed [kwm_pkg::SAMPLE_W-1:0] in_sample,
    output logic                            in_ready,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic signed [kwm_pkg::SAMPLE_W-1:0] res_sample,
    output logic                            res_last,
    output logic                            u_start,
    output kwm_pkg::unit_req_t              u_req,
    input  logic                            u_done,
    input  logic [127:0]                    u_result
);
    import kwm_pkg::*;

    localparam int KW = $clog2(SERIES_TERMS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_BB_Y, S_BB_YW, S_BB_MUL, S_BB_MULW, S_BB_DIV, S_BB_DIVW,
        S_SQRT, S_SQRTW, S_SDIV, S_SDIVW, S_XMUL, S_XMULW, S_Y, S_YW,
        S_MUL, S_MULW, S_DIV, S_DIVW, S_WDIV, S_WDIVW,
        S_OMUL, S_OMULW, S_GMUL, S_GMULW, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [15:0]            index_reg;
    logic [BESSEL_W-1:0]    bb_reg;
    logic [15:0]            smp_mag_reg;
    logic                   smp_neg_reg;
    logic                   last_reg;
    logic [16:0]            s_reg;
    logic [63:0]            y_reg;
    logic [63:0]            u_reg;
    logic [63:0]            sum_reg;
    logic [KW-1:0]          k_reg;
    logic [63:0]            tmp_reg;
    logic [WEIGHT_W-1:0]    w_reg;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic                   start_reg;
    unit_req_t              req_reg;
    logic                   bb_mode_reg;

    logic [15:0]  lm1;
    logic         last_c;
    logic [63:0]  sum_sat;
    logic [63:0]  kk;
    logic [127:0] mag_full;

    always_comb begin
        lm1     = (frame_length >= 16'd2) ? frame_length - 16'd1 : 16'd0;
        last_c  = (frame_length < 16'd2) || (index_reg >= lm1);
        sum_sat = (sum_reg > {16'd0, MAX_Q28}) ? {16'd0, MAX_Q28} : sum_reg;
        kk      = 64'(k_reg) * 64'(k_reg);
        mag_full = u_result >> 45;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            index_reg <= 16'd0;
            bb_reg    <= '0;
            start_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (in_valid) begin
                    smp_neg_reg <= in_sample[SAMPLE_W-1];
                    smp_mag_reg <= in_sample[SAMPLE_W-1] ? 16'(-in_sample) : in_sample;
                    last_reg    <= last_c;
                    if (index_reg == 16'd0 || bb_reg == '0) begin
                        bb_mode_reg <= 1'b1;
                        tmp_reg     <= {44'd0, beta, 4'd0};
                        state_reg   <= S_Y;
                    end else begin
                        bb_mode_reg <= 1'b0;
                        state_reg   <= S_SQRT;
                    end
                end
                // square root of n*(L-1-n) << 32
                S_SQRT: begin
                    bb_mode_reg <= 1'b0;
                    if (last_reg) begin
                        s_reg     <= 17'd0;
                        state_reg <= S_XMUL;
                    end else begin
                        req_reg   <= '{OP_SQRT,
                            (64'(index_reg) * 64'(lm1 - index_reg)) << 32, 64'd0, 7'd32};
                        start_reg <= 1'b1;
                        state_reg <= S_SQRTW;
                    end
                end
                S_SQRTW: if (u_done) begin
                    req_reg   <= '{OP_DIV, {u_result[62:0], 1'b0} << 0, 64'(lm1), 7'd64};
                    start_reg <= 1'b1;
                    state_reg <= S_SDIVW;
                end
                S_SDIVW: if (u_done) begin
                    s_reg     <= (u_result[63:0] > 64'd65536) ? 17'd65536 : u_result[16:0];
                    state_reg <= S_XMUL;
                end
                S_XMUL: begin
                    req_reg   <= '{OP_MUL, 64'(beta), 64'(s_reg), 7'd9};
                    start_reg <= 1'b1;
                    state_reg <= S_XMULW;
                end
                S_XMULW: if (u_done) begin
                    tmp_reg   <= 64'(u_result[63:12]);
                    state_reg <= S_Y;
                end
                // y = x*x >> 2, then the series
                S_Y: begin
                    req_reg   <= '{OP_MUL, tmp_reg, tmp_reg, 7'd16};
                    start_reg <= 1'b1;
                    state_reg <= S_YW;
                end
                S_YW: if (u_done) begin
                    y_reg     <= u_result[65:2];
                    u_reg     <= {16'd0, ONE_Q28};
                    sum_reg   <= {16'd0, ONE_Q28};
                    k_reg     <= KW'(1);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    req_reg   <= '{OP_MUL, u_reg, y_reg, 7'd32};
                    start_reg <= 1'b1;
                    state_reg <= S_MULW;
                end
                S_MULW: if (u_done) begin
                    req_reg   <= '{OP_DIV, u_result[95:32], kk, 7'd64};
                    start_reg <= 1'b1;
                    state_reg <= S_DIVW;
                end
                S_DIVW: if (u_done) begin
                    u_reg   <= u_result[63:0];
                    sum_reg <= sum_reg + u_result[63:0];
                    if (k_reg == KW'(SERIES_TERMS)) begin
                        state_reg <= S_WDIV;
                    end else begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_MUL;
                    end
                end
                S_WDIV: begin
                    if (bb_mode_reg) begin
                        bb_reg    <= sum_sat[BESSEL_W-1:0];
                        state_reg <= S_SQRT;
                    end else if (sum_sat >= {16'd0, bb_reg}) begin
                        w_reg     <= ONE_Q30;
                        state_reg <= S_OMUL;
                    end else begin
                        // dividend num << 16, then 14 more zero bits shift in
                        req_reg   <= '{OP_DIV, sum_sat << 16, {16'd0, bb_reg}, 7'd78};
                        start_reg <= 1'b1;
                        state_reg <= S_WDIVW;
                    end
                end
                S_WDIVW: if (u_done) begin
                    w_reg     <= u_result[WEIGHT_W-1:0];
                    state_reg <= S_OMUL;
                end
                S_OMUL: begin
                    req_reg   <= '{OP_MUL, 64'(w_reg) * 64'(OUT_GAIN), 64'(smp_mag_reg), 7'd8};
                    start_reg <= 1'b1;
                    state_reg <= S_OMULW;
                end
                S_OMULW: if (u_done) begin
                    if (smp_neg_reg)
                        out_reg <= (mag_full > 128'd32768) ? -16'sd32768
                                 : SAMPLE_W'(-mag_full[16:0]);
                    else
                        out_reg <= (mag_full > 128'd32767) ? 16'sd32767
                                 : SAMPLE_W'(mag_full[15:0]);
                    index_reg <= last_reg ? 16'd0 : index_reg + 16'd1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (res_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res_sample = out_reg;
    assign res_last   = last_reg;
    assign u_start    = start_reg;
    assign u_req      = req_reg;

endmodule

// ===== bench/kwm_window_checker.sv =====
module kwm_window_checker
    import kwm_pkg::*;
#(
    parameter int SERIES_TERMS = 50
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       m_frame_last,
    output int                         error_count,
    output int                         pending_count,
    output int                         frame_count
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       frame_last;
    } windowed_t;

    windowed_t windowed_q[$];

    // Shadow copy of the registers and the frame state
    logic [CFG_W-1:0]    shadow_len;
    logic [CFG_W-1:0]    shadow_beta;
    logic [15:0]         frame_pos;
    logic [BESSEL_W-1:0] i0_of_beta;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // I0 of a Q4.16 argument as Q20.28, truncated power series
    function automatic longint unsigned series_i0(longint unsigned x16);
        longint unsigned y;
        longint unsigned u;
        longint unsigned acc;
        logic [127:0]    prod;
        y   = (x16 * x16) >> 2;
        u   = 64'd1 << 28;
        acc = 64'd1 << 28;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            prod = 128'(u) * 128'(y);
            u    = 64'(prod >> 32) / 64'(k * k);
            acc  = acc + u;
        end
        if (acc > 64'(MAX_Q28)) acc = 64'(MAX_Q28);
        return acc;
    endfunction

    // Q1.30 ratio, limited to one
    function automatic longint unsigned ratio_q30(longint unsigned num,
                                                  longint unsigned den);
        logic [127:0] wide;
        if (num >= den) return 64'd1 << 30;
        wide = (128'(num) << 30) / 128'(den);
        return 64'(wide);
    endfunction

    function automatic windowed_t window_sample(logic signed [SAMPLE_W-1:0] smp,
                                                logic [15:0] n,
                                                logic [CFG_W-1:0] len,
                                                logic [CFG_W-1:0] b,
                                                longint unsigned den);
        windowed_t       r;
        longint unsigned lm1;
        longint unsigned s;
        longint unsigned p;
        longint unsigned w;
        longint unsigned mag;
        longint signed   val;
        lm1 = (len >= 2) ? 64'(len) - 1 : 0;
        r.frame_last = (len < 2) || (64'(n) >= lm1);
        s = 0;
        if (len >= 2 && 64'(n) < lm1) begin
            p = 64'(n) * (lm1 - 64'(n));
            s = (2 * int_sqrt(p << 32)) / lm1;
            if (s > 65536) s = 65536;
        end
        w   = ratio_q30(series_i0((64'(b) * s) >> 12), den);
        mag = 64'(smp < 0 ? -32'(smp) : 32'(smp));
        mag = (mag * w * 64'd32767) >> 45;
        val = (smp < 0) ? -longint'(mag) : longint'(mag);
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        r.sample_out = SAMPLE_W'(val);
        return r;
    endfunction

    assign pending_count = windowed_q.size();

    always @(posedge aclk) begin
        windowed_t exp_item;
        if (!aresetn) begin
            shadow_len  = 16'd1024;
            shadow_beta = 16'd20480;
            frame_pos   = '0;
            i0_of_beta  = '0;
            windowed_q.delete();
            error_count <= 0;
            frame_count <= 0;
        end else begin
            // track register writes
            if (cfg_we) begin
                if (cfg_index == CFG_FRAME_LENGTH) shadow_len = cfg_data;
                else shadow_beta = cfg_data;
            end
            // predict each accepted item
            if (s_valid && s_ready) begin
                if (frame_pos == 0 || i0_of_beta == 0)
                    i0_of_beta = BESSEL_W'(series_i0(64'(shadow_beta) << 4));
                exp_item = window_sample(s_sample_in, frame_pos, shadow_len,
                                         shadow_beta, 64'(i0_of_beta));
                windowed_q.push_back(exp_item);
                frame_pos = exp_item.frame_last ? 16'd0 : frame_pos + 16'd1;
            end
            // compare each delivered item
            if (m_valid && m_ready) begin
                if (windowed_q.size() == 0) begin
                    $error("unexpected item: sample_out %0d frame_last %0b",
                           m_sample_out, m_frame_last);
                    error_count <= error_count + 1;
                end else begin
                    exp_item = windowed_q.pop_front();
                    if (m_frame_last) frame_count <= frame_count + 1;
                    if (exp_item.sample_out !== m_sample_out ||
                        exp_item.frame_last !== m_frame_last)
                        error_count <= error_count + 1;
                    if (exp_item.sample_out !== m_sample_out)
                        $error("sample_out: expected %0d actual %0d",
                               exp_item.sample_out, m_sample_out);
                    if (exp_item.frame_last !== m_frame_last)
                        $error("frame_last: expected %0b actual %0b",
                               exp_item.frame_last, m_frame_last);
                end
            end
        end
    end

endmodule

// ===== bench/tb_kaiser_window_multiplier_core.sv =====
module tb_kaiser_window_multiplier_core;
    import kwm_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd80_000_000;
    localparam int     RANDOM_ITEMS = 1330;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_FRAME_LENGTH;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [15:0] s_sample_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_sample_out;
    logic        m_frame_last;

    int     error_count;
    int     pending_count;
    int     frame_count;
    int     sent_count = 0;
    int     phase_count = 0;
    bit     calm = 1'b0;
    longint cycle_count = 0;

    kaiser_window_multiplier_core u_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_sample_in,
        .m_valid, .m_ready, .m_sample_out, .m_frame_last
    );

    kwm_window_checker u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_sample_in,
        .m_valid, .m_ready, .m_sample_out, .m_frame_last,
        .error_count, .pending_count, .frame_count
    );

    always #5 aclk = ~aclk;

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_kaiser_window_multiplier_core: errors");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_sample(logic signed [15:0] v);
        s_valid     <= 1'b1;
        s_sample_in <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Drain, then write both registers back to back
    task automatic set_window(logic [15:0] len, logic [15:0] b);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_LENGTH;
        cfg_data  <= len;
        @(posedge aclk);
        cfg_index <= CFG_BETA;
        cfg_data  <= b;
        @(posedge aclk);
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'(signed'($urandom_range(0, 4)) - 2);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] len;
        logic [15:0] b;
        int          burst;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults after reset, extreme samples
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        // Shortest legal frame, flat window
        set_window(16'd2, 16'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        // Short frame lengths: every sample ends a frame
        set_window(16'd1, 16'hFFFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        set_window(16'd0, 16'd20480);
        send_sample(16'sh4000);
        send_sample(16'shC000);
        // Odd frame, steepest shape
        set_window(16'd5, 16'hFFFF);
        repeat (3) send_sample(16'sh7FFF);
        // Shrink the frame mid-way: index lands past the end
        set_window(16'd3, 16'h1000);
        send_sample(16'sh8000);
        send_sample(16'sh5555);
        // Change the shape mid-frame: cached I0 stays
        set_window(16'd3, 16'hF000);
        send_sample(16'sh7FFF);
        send_sample(16'shAAAA);
        // Longest frame, a few items only
        set_window(16'hFFFF, 16'd12345);
        send_sample(16'sh7FFF);
        send_sample(16'sh8001);

        // Random phases, mostly short frames
        while (sent_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 15))
                0:       len = 16'($urandom_range(0, 1));
                1:       len = 16'hFFFF;
                2:       len = 16'($urandom());
                default: len = 16'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       b = 16'd0;
                1:       b = 16'hFFFF;
                default: b = 16'($urandom());
            endcase
            set_window(len, b);
            burst = $urandom_range(4, 40);
            repeat (burst) begin
                if (sent_count > RANDOM_ITEMS - 60) calm = 1'b1;
                send_sample(pick_sample());
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("covered %0d items over %0d window settings, %0d frame ends seen",
                 sent_count, phase_count, frame_count);
        if (error_count == 0) begin
            $display("tb_kaiser_window_multiplier_core: clean");
        end else begin
            $display("tb_kaiser_window_multiplier_core: errors");
        end
        $finish;
    end

endmodule
